// ----- hdl/gws_pkg.sv -----
// Shared types and constants for the gated window statistics block.
`timescale 1ns / 1ps
`default_nettype none
package gws_pkg;
    localparam int SAMPLE_BITS = 12;
    localparam int MAX_WINDOW  = 4096;
    localparam int NUM_LANES   = 6;
    localparam int LANE_W      = $clog2(NUM_LANES);
    localparam int VAL_W       = SAMPLE_BITS + 1;
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W       = VAL_W + CNT_W;
    localparam int MAG_W       = SUM_W - 1;
    localparam int STEP_W      = $clog2(MAG_W + 1);
    localparam int HALF_LIMIT  = (1 << (SAMPLE_BITS - 1)) - 1;

    localparam logic [LANE_W-1:0] CH_HALF = LANE_W'(4);
    localparam logic [LANE_W-1:0] CH_TEMP = LANE_W'(5);

    localparam logic [SAMPLE_BITS-1:0] THRESH_RESET = SAMPLE_BITS'(1551);
    localparam logic [CNT_W-1:0]       MINCNT_RESET = CNT_W'(20);

    localparam logic REG_THRESH = 1'b0;
    localparam logic REG_MINCNT = 1'b1;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [SUM_W-1:0] sum_t;

    typedef enum logic [1:0] {
        ST_ACC,
        ST_DIV,
        ST_WAIT,
        ST_OUT
    } gws_state_t;

    localparam val_t RF_MIN_INIT   = val_t'((1 << SAMPLE_BITS) - 1);
    localparam val_t RF_MAX_INIT   = val_t'(0);
    localparam val_t HALF_MIN_INIT = val_t'(HALF_LIMIT);
    localparam val_t HALF_MAX_INIT = val_t'(-HALF_LIMIT);
endpackage
`default_nettype wire

// ----- hdl/gws_lane.sv -----
// One statistics lane: running minimum, maximum and sum of a channel.
`timescale 1ns / 1ps
`default_nettype none
module gws_lane
    import gws_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic upd,
    input  wire logic clr,
    input  wire val_t val,
    input  wire val_t min_init,
    input  wire val_t max_init,
    output val_t      min_val,
    output val_t      max_val,
    output sum_t      sum_val
);
    logic seen_reg, seen_next;
    val_t min_reg, min_next;
    val_t max_reg, max_next;
    sum_t sum_reg, sum_next;

    always_comb
    begin
        seen_next = seen_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        sum_next  = sum_reg;
        if (clr)
        begin
            seen_next = 1'b0;
        end
        else if (upd)
        begin
            seen_next = 1'b1;
            // first sample of the window loads all three directly
            min_next  = (!seen_reg || val < min_reg) ? val : min_reg;
            max_next  = (!seen_reg || val > max_reg) ? val : max_reg;
            sum_next  = seen_reg ? sum_reg + SUM_W'(val) : SUM_W'(val);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= 1'b0;
        end
        else
        begin
            seen_reg <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
        sum_reg <= sum_next;
    end

    assign min_val = seen_reg ? min_reg : min_init;
    assign max_val = seen_reg ? max_reg : max_init;
    assign sum_val = seen_reg ? sum_reg : '0;
endmodule
`default_nettype wire

// ----- hdl/gws_div.sv -----
// Restoring divider, one quotient bit per cycle, unsigned.
`timescale 1ns / 1ps
`default_nettype none
module gws_div
    import gws_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [MAG_W-1:0] dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic [MAG_W-1:0]      quotient
);
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [MAG_W-1:0]  quo_reg, quo_next;
    logic [CNT_W:0]    rem_reg, rem_next;
    logic [CNT_W-1:0]  dvs_reg, dvs_next;
    logic [CNT_W:0]    rem_shift;

    always_comb
    begin
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        rem_shift = {rem_reg[CNT_W-1:0], quo_reg[MAG_W-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            step_next = STEP_W'(MAG_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_shift >= {1'b0, dvs_reg})
            begin
                rem_next = rem_shift - {1'b0, dvs_reg};
                quo_next = {quo_reg[MAG_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift;
                quo_next = {quo_reg[MAG_W-2:0], 1'b0};
            end
            step_next = step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

// ----- hdl/gated_window_statistics_top.sv -----
// Top level of the gated window statistics block.
//
//  channel  dir  fields (lsb first)
//  s_*      in   tdata: fwd, pos, neg, rev, temp (12b each); tlast: window_end
//  m_*      out  tdata: minimum, maximum, average, sample_count, window_valid;
//                tuser: channel; tlast: last
//  apb      in   0x0 gate_threshold, 0x4 min_valid_count
//
//  One sample request per cycle while the window is open.
//  A window end stops input; each of the six results then passes through
//  a setup state, the shared serial divider (skipped when the count is
//  zero) and an output state, held until taken.
//  Reset is asynchronous, active low; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module gated_window_statistics_top
    import gws_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // fwd[11:0] pos[23:12] neg[35:24] rev[47:36] temp[59:48], rest zero
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // minimum[12:0] maximum[25:13] average[38:26] count[51:39] valid[52]
    output logic [55:0]      m_tdata,
    // channel[2:0]
    output logic [2:0]       m_tuser,
    output logic             m_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    localparam int SB = SAMPLE_BITS;

    // configuration
    logic [SB-1:0]    thresh_reg;
    logic [CNT_W-1:0] mincnt_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= THRESH_RESET;
            mincnt_reg <= MINCNT_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_THRESH: thresh_reg <= pwdata[SB-1:0];
                REG_MINCNT: mincnt_reg <= pwdata[CNT_W-1:0];
                default:    thresh_reg <= thresh_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_THRESH: prdata = 32'(thresh_reg);
            REG_MINCNT: prdata = 32'(mincnt_reg);
            default:    prdata = '0;
        endcase
    end

    // input fields
    logic [SB-1:0] fwd, pos, neg, rev, tmp;
    assign fwd = s_tdata[SB-1:0];
    assign pos = s_tdata[2*SB-1:SB];
    assign neg = s_tdata[3*SB-1:2*SB];
    assign rev = s_tdata[4*SB-1:3*SB];
    assign tmp = s_tdata[5*SB-1:4*SB];

    // sequencer
    gws_state_t       state_reg, state_next;
    logic [LANE_W-1:0] ch_reg, ch_next;
    logic [CNT_W-1:0] gcnt_reg, gcnt_next;
    logic [CNT_W-1:0] tcnt_reg, tcnt_next;
    val_t             avg_reg, avg_next;
    logic             accept, in_window, gated, clr, div_start, div_done;

    assign accept    = s_tvalid && s_tready;
    assign in_window = tcnt_reg < CNT_W'(MAX_WINDOW);
    assign gated     = (fwd < thresh_reg) || (rev < thresh_reg);

    // half difference, truncated toward zero
    val_t diff, half;
    assign diff = val_t'({1'b0, pos}) - val_t'({1'b0, neg});
    assign half = (diff + val_t'(diff[VAL_W-1])) >>> 1;

    // lanes
    val_t lane_val  [NUM_LANES];
    val_t lane_minv [NUM_LANES];
    val_t lane_maxv [NUM_LANES];
    val_t lane_min  [NUM_LANES];
    val_t lane_max  [NUM_LANES];
    sum_t lane_sum  [NUM_LANES];
    logic lane_upd  [NUM_LANES];

    assign lane_val[0] = val_t'({1'b0, fwd});
    assign lane_val[1] = val_t'({1'b0, pos});
    assign lane_val[2] = val_t'({1'b0, neg});
    assign lane_val[3] = val_t'({1'b0, rev});
    assign lane_val[4] = half;
    assign lane_val[5] = val_t'({1'b0, tmp});

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        assign lane_minv[i] = (i == 4) ? HALF_MIN_INIT : RF_MIN_INIT;
        assign lane_maxv[i] = (i == 4) ? HALF_MAX_INIT : RF_MAX_INIT;
        assign lane_upd[i]  = accept && in_window && ((i == 5) || gated);
        gws_lane u_lane (
            .clk      (clk),
            .rst_n    (rst_n),
            .upd      (lane_upd[i]),
            .clr      (clr),
            .val      (lane_val[i]),
            .min_init (lane_minv[i]),
            .max_init (lane_maxv[i]),
            .min_val  (lane_min[i]),
            .max_val  (lane_max[i]),
            .sum_val  (lane_sum[i])
        );
    end

    // merge: pick the lane under readout
    sum_t             sel_sum;
    logic [CNT_W-1:0] sel_cnt;
    logic [MAG_W-1:0] sel_mag;
    logic [MAG_W-1:0] quo;
    logic             win_ok;
    val_t             quo_s;

    assign sel_sum = lane_sum[ch_reg];
    assign sel_cnt = (ch_reg == CH_TEMP) ? tcnt_reg : gcnt_reg;
    assign sel_mag = sel_sum[SUM_W-1] ? MAG_W'(-sel_sum) : MAG_W'(sel_sum);
    assign quo_s   = val_t'(quo[VAL_W-1:0]);
    assign win_ok  = (gcnt_reg != '0) && (gcnt_reg >= mincnt_reg);

    gws_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sel_mag),
        .divisor  (sel_cnt),
        .done     (div_done),
        .quotient (quo)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_ACC:  if (accept && s_tlast) state_next = ST_DIV;
            ST_DIV:  state_next = (sel_cnt == '0) ? ST_OUT : ST_WAIT;
            ST_WAIT: if (div_done) state_next = ST_OUT;
            ST_OUT:
            begin
                if (m_tready)
                begin
                    state_next = (ch_reg == CH_TEMP) ? ST_ACC : ST_DIV;
                end
            end
            default: state_next = ST_ACC;
        endcase
    end

    // outputs and datapath control
    always_comb
    begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        div_start = 1'b0;
        clr       = 1'b0;
        ch_next   = ch_reg;
        avg_next  = avg_reg;
        gcnt_next = gcnt_reg;
        tcnt_next = tcnt_reg;
        case (state_reg)
            ST_ACC:
            begin
                s_tready = 1'b1;
                ch_next  = '0;
                if (accept && in_window)
                begin
                    tcnt_next = tcnt_reg + CNT_W'(1);
                    if (gated)
                    begin
                        gcnt_next = gcnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_DIV:
            begin
                if (sel_cnt == '0)
                begin
                    avg_next = '0;
                end
                else
                begin
                    div_start = 1'b1;
                end
            end
            ST_WAIT:
            begin
                if (div_done)
                begin
                    avg_next = sel_sum[SUM_W-1] ? -quo_s : quo_s;
                end
            end
            ST_OUT:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    if (ch_reg == CH_TEMP)
                    begin
                        ch_next   = '0;
                        clr       = 1'b1;
                        gcnt_next = '0;
                        tcnt_next = '0;
                    end
                    else
                    begin
                        ch_next = ch_reg + LANE_W'(1);
                    end
                end
            end
            default: s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACC;
            ch_reg    <= '0;
            gcnt_reg  <= '0;
            tcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            gcnt_reg  <= gcnt_next;
            tcnt_reg  <= tcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        avg_reg <= avg_next;
    end

    assign m_tuser = 3'(ch_reg);
    assign m_tlast = (ch_reg == CH_TEMP);
    assign m_tdata = {3'b000, win_ok, sel_cnt, avg_reg,
                      lane_max[ch_reg], lane_min[ch_reg]};

    // checks
    a_one_side : assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input and output open together");

    a_cnt_order : assert property (@(posedge clk) disable iff (!rst_n)
        gcnt_reg <= tcnt_reg)
        else $error("gated count above total count");

    a_end_clear : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> (tcnt_reg == '0 && s_tready))
        else $error("window not cleared after last result");

    a_div_wait : assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == ST_WAIT && !div_done))
        else $error("divider result too early");
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// Testbench for gated_window_statistics_top: scoreboard-checked directed and random windows.
`timescale 1ns / 1ps
module tb;
    import gws_pkg::*;

    // Register byte addresses
    localparam logic [2:0] ADDR_THRESH = 3'd0;
    localparam logic [2:0] ADDR_MINCNT = 3'd4;

    typedef struct {
        logic [2:0]  ch;
        logic [12:0] mn;
        logic [12:0] mx;
        logic [12:0] avg;
        logic [12:0] cnt;
        logic        vld;
        logic        lst;
    } stat_result_t;

    // Keeps its own copy of the window accumulators and predicts the six
    // per-channel results that each window end produces.
    class window_stats_board;
        logic [11:0]  thresh;
        logic [12:0]  min_cnt;
        int           rf_lo[4];
        int           rf_hi[4];
        int           rf_sum[4];
        int           hd_lo;
        int           hd_hi;
        int           hd_sum;
        int           tp_lo;
        int           tp_hi;
        int           tp_sum;
        int           gated_n;
        int           total_n;
        stat_result_t expected_q[$];
        int           errors;

        function void reset_all();
            thresh  = 12'd1551;
            min_cnt = 13'd20;
            errors  = 0;
            clear_window();
        endfunction

        function void clear_window();
            for (int c = 0; c < 4; c++)
            begin
                rf_lo[c]  = 4095;
                rf_hi[c]  = 0;
                rf_sum[c] = 0;
            end
            hd_lo   = HALF_LIMIT;
            hd_hi   = -HALF_LIMIT;
            hd_sum  = 0;
            tp_lo   = 4095;
            tp_hi   = 0;
            tp_sum  = 0;
            gated_n = 0;
            total_n = 0;
        endfunction

        function void push_result(int ch, int mn, int mx, int sum, int cnt, bit vld);
            stat_result_t r;
            r.ch  = 3'(ch);
            r.mn  = 13'(mn);
            r.mx  = 13'(mx);
            r.avg = (cnt != 0) ? 13'(sum / cnt) : 13'd0;
            r.cnt = 13'(cnt);
            r.vld = (cnt != 0) ? vld : 1'b0;
            r.lst = (ch == 5);
            expected_q.push_back(r);
        endfunction

        // Called for every accepted sample request.
        function void note_sample(logic [11:0] s[5], logic wend);
            int hd;
            bit vld;
            if (total_n < MAX_WINDOW)
            begin
                if (s[0] < thresh || s[3] < thresh)
                begin
                    hd = (int'(s[1]) - int'(s[2])) / 2;   // truncates toward zero
                    gated_n++;
                    for (int c = 0; c < 4; c++)
                    begin
                        if (s[c] < rf_lo[c]) rf_lo[c] = s[c];
                        if (s[c] > rf_hi[c]) rf_hi[c] = s[c];
                        rf_sum[c] += s[c];
                    end
                    if (hd < hd_lo) hd_lo = hd;
                    if (hd > hd_hi) hd_hi = hd;
                    hd_sum += hd;
                end
                if (s[4] < tp_lo) tp_lo = s[4];
                if (s[4] > tp_hi) tp_hi = s[4];
                tp_sum += s[4];
                total_n++;
            end
            if (!wend)
                return;
            vld = (gated_n != 0) && (gated_n >= min_cnt);
            for (int c = 0; c < 4; c++)
                push_result(c, rf_lo[c], rf_hi[c], rf_sum[c], gated_n, vld);
            push_result(4, hd_lo, hd_hi, hd_sum, gated_n, vld);
            push_result(5, tp_lo, tp_hi, tp_sum, total_n, vld);
            clear_window();
        endfunction

        function void check_result(logic [55:0] d, logic [2:0] u, logic l);
            stat_result_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result ch=%0d data=%h", $time, u, d);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (u !== e.ch)
                report("channel", e.ch, u);
            if (d[12:0] !== e.mn)
                report("minimum", e.mn, d[12:0]);
            if (d[25:13] !== e.mx)
                report("maximum", e.mx, d[25:13]);
            if (d[38:26] !== e.avg)
                report("average", e.avg, d[38:26]);
            if (d[51:39] !== e.cnt)
                report("sample_count", e.cnt, d[51:39]);
            if (d[52] !== e.vld)
                report("window_valid", e.vld, d[52]);
            if (l !== e.lst)
                report("last", e.lst, l);
        endfunction

        function void report(string what, logic [12:0] exp_v, logic [12:0] act_v);
            $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
            errors++;
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [63:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    window_stats_board board = new();
    bit                calm = 1'b0;     // no idling on either side while set
    int                mode = 0;        // sample shaping for the random part

    always #5 clk = ~clk;

    gated_window_statistics_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Result side: random backpressure, checks at the rising edge.
    initial
    begin
        forever
        begin
            @(negedge clk);
            m_tready <= calm || ($urandom_range(99) >= 13);
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                board.check_result(m_tdata, m_tuser, m_tlast);
        end
    end

    // One sample request; random idle cycles before it.
    task automatic send_sample(logic [11:0] s[5], logic wend);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 13)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tdata  <= {4'b0, s[4], s[3], s[2], s[1], s[0]};
        s_tlast  <= wend;
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        board.note_sample(s, wend);
    endtask

    // Stop sending and wait for every predicted result.
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // APB write then read back; only done while the block is idle.
    task automatic reg_write(logic [2:0] addr, logic [31:0] value);
        logic [31:0] want;
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= addr; pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        pwrite <= 1'b0; penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (addr == ADDR_THRESH)
        begin
            board.thresh = value[11:0];
            want = {20'b0, value[11:0]};
        end
        else
        begin
            board.min_cnt = value[12:0];
            want = {19'b0, value[12:0]};
        end
        if (prdata !== want)
        begin
            $display("%0t: register %0d readback, expected %h, got %h",
                     $time, addr, want, prdata);
            board.errors++;
        end
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0;
    endtask

    function automatic logic [11:0] pick_reading();
        case ($urandom_range(9))
            0: return 12'd0;
            1: return 12'hFFF;
            2: return 12'(board.thresh + $urandom_range(2) - 1);   // around the gate
            default: return 12'($urandom_range(4095));
        endcase
    endfunction

    task automatic send_random(logic wend);
        logic [11:0] s[5];
        for (int i = 0; i < 5; i++)
            s[i] = pick_reading();
        // mostly transmit samples, so the RF statistics get work
        if (mode == 0 && $urandom_range(3) != 0)
            s[$urandom_range(1) * 3] = 12'($urandom_range(board.thresh));
        send_sample(s, wend);
    endtask

    task automatic send_five(int f, int p, int n, int r, int t, logic wend);
        logic [11:0] s[5];
        s = '{12'(f), 12'(p), 12'(n), 12'(r), 12'(t)};
        send_sample(s, wend);
    endtask

    initial
    begin
        int sent;
        int len;
        board.reset_all();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, reset configuration first.
        send_five(0, 100, 50, 4095, 7, 1'b1);            // lone gated sample, below minimum
        send_five(4095, 1, 2, 4095, 4095, 1'b1);         // empty channel: nothing gated
        send_five(10, 4095, 0, 4095, 0, 1'b0);           // half difference extremes
        send_five(4095, 0, 4095, 20, 4095, 1'b0);
        send_five(1, 1, 0, 1, 3000, 1'b0);               // +1/2 truncates to 0
        send_five(1, 0, 3, 1, 5, 1'b1);                  // -3/2 truncates to -1
        drain();
        reg_write(ADDR_MINCNT, 32'd0);                   // zero minimum
        reg_write(ADDR_THRESH, 32'd4095);
        send_five(4094, 5, 9, 4095, 12, 1'b1);
        send_five(4095, 5, 9, 4095, 12, 1'b1);           // empty with zero minimum
        drain();
        reg_write(ADDR_THRESH, 32'd0);                   // nothing can gate
        send_five(0, 0, 0, 0, 0, 1'b0);
        send_five(0, 4095, 4095, 0, 4095, 1'b1);
        drain();
        reg_write(ADDR_MINCNT, 32'd4096);
        reg_write(ADDR_THRESH, 32'd1551);
        send_five(0, 4095, 0, 0, 4095, 1'b1);            // below the largest minimum
        drain();

        // Random windows with occasional configuration changes.
        sent = 0;
        while (sent < 220)
        begin
            if ($urandom_range(3) == 0)
            begin
                drain();
                case ($urandom_range(4))
                    0: reg_write(ADDR_THRESH, 32'd0);
                    1: reg_write(ADDR_THRESH, 32'd4095);
                    default: reg_write(ADDR_THRESH, $urandom_range(4095));
                endcase
                case ($urandom_range(5))
                    0: reg_write(ADDR_MINCNT, 32'd0);
                    1: reg_write(ADDR_MINCNT, 32'd1);
                    default: reg_write(ADDR_MINCNT, $urandom_range(25));
                endcase
            end
            mode = ($urandom_range(4) == 0);
            calm = (sent >= 90 && sent < 150);           // one long stretch without gaps
            len = $urandom_range(1, 30);
            for (int i = 0; i < len; i++)
                send_random(i == len - 1);
            sent += len;
        end
        calm = 1'b0;
        drain();

        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/gws_pkg.sv
hdl/gws_lane.sv
hdl/gws_div.sv
hdl/gated_window_statistics_top.sv
tb/tb.sv
